/* sv/isc_pkg.sv */
// ---------------------------------------------------------------------------
// isc_pkg - shared types and constants of the image scaler
// Store geometry, fixed-point widths, register indexes and the structs
// passed between the coordinate, fetch and blend stages.
// ---------------------------------------------------------------------------
`default_nettype none

package isc_pkg;

  // store geometry (powers of two: a store address is {row, col})
  localparam int MAX_SRC_WIDTH  = 256;
  localparam int MAX_SRC_HEIGHT = 256;
  localparam int COL_W          = $clog2(MAX_SRC_WIDTH);
  localparam int ROW_W          = $clog2(MAX_SRC_HEIGHT);
  localparam int ADDR_W         = ROW_W + COL_W;
  localparam int STORE_DEPTH    = MAX_SRC_WIDTH * MAX_SRC_HEIGHT;

  // field widths
  localparam int COORD_W   = 12;
  localparam int DIM_W     = 9;
  localparam int STEP_W    = 25;
  localparam int CH_W      = 8;
  localparam int NUM_CH    = 3;
  localparam int PIX_W     = CH_W * NUM_CH;
  localparam int CFG_IDX_W = 3;

  // fixed point
  localparam int FRAC_BITS = 16;
  localparam int POS_W     = COORD_W + STEP_W;
  localparam int KN_W      = POS_W + 1 - FRAC_BITS;
  localparam int WT_W      = FRAC_BITS + 1;
  localparam int H_W       = CH_W + FRAC_BITS;
  localparam int ACC_W     = CH_W + 2 * FRAC_BITS;

  localparam logic [WT_W-1:0]  ONE_FX  = WT_W'(1) << FRAC_BITS;
  localparam logic [POS_W:0]   HALF_FX = (POS_W + 1)'(1) << (FRAC_BITS - 1);

  // register reset values
  localparam logic [DIM_W-1:0]  SRC_WIDTH_RST  = DIM_W'(256);
  localparam logic [DIM_W-1:0]  SRC_HEIGHT_RST = DIM_W'(256);
  localparam logic [STEP_W-1:0] STEP_RST       = STEP_W'(65536);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SRC_WIDTH  = 3'd0,
    REG_SRC_HEIGHT = 3'd1,
    REG_ROW_STEP   = 3'd2,
    REG_COL_STEP   = 3'd3,
    REG_INTERP     = 3'd4
  } cfg_reg_t;

  typedef enum logic {
    FUNC_LOAD    = 1'b0,
    FUNC_REQUEST = 1'b1
  } func_t;

  typedef logic [ADDR_W-1:0] addr_t;

  // one item as handed to the fetch stage
  typedef struct packed {
    logic                 is_load;
    logic                 wr_en;
    logic                 bilin;
    addr_t [3:0]          addr;
    logic [FRAC_BITS-1:0] fx;
    logic [FRAC_BITS-1:0] fy;
    logic [PIX_W-1:0]     pix;
  } fetch_req_t;

  // four gathered neighbours with their weights
  typedef struct packed {
    logic                   valid;
    logic [FRAC_BITS-1:0]   fx;
    logic [FRAC_BITS-1:0]   fy;
    logic [3:0][PIX_W-1:0]  pix;
  } quad_t;

  // weighted top and bottom terms of one channel
  typedef struct packed {
    logic [ACC_W-1:0] top;
    logic [ACC_W-1:0] bot;
  } lane_prod_t;

endpackage

`default_nettype wire

/* sv/isc_coord.sv */
// ---------------------------------------------------------------------------
// isc_coord - input register, coordinate scaling and neighbour addressing
// Registers the accepted beat, multiplies by the steps, then clamps and
// splits the scaled coordinates into store addresses and fractions.
// ---------------------------------------------------------------------------
`default_nettype none

module isc_coord (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic                          func,
  input  logic [isc_pkg::COORD_W-1:0]   row,
  input  logic [isc_pkg::COORD_W-1:0]   col,
  input  logic [isc_pkg::PIX_W-1:0]     pix,
  input  logic [isc_pkg::DIM_W-1:0]     src_width,
  input  logic [isc_pkg::DIM_W-1:0]     src_height,
  input  logic [isc_pkg::STEP_W-1:0]    row_step,
  input  logic [isc_pkg::STEP_W-1:0]    col_step,
  input  logic                          blend_mode,
  input  logic                          req_ready,
  output logic                          busy,
  output logic                          req_valid,
  output isc_pkg::fetch_req_t           req
);

  logic                          accept;
  logic                          s1_free;
  logic                          s2_free;

  logic                          s1_valid;
  logic                          s1_func;
  logic [isc_pkg::COORD_W-1:0]   s1_row;
  logic [isc_pkg::COORD_W-1:0]   s1_col;
  logic [isc_pkg::PIX_W-1:0]     s1_pix;

  logic                          s2_valid;
  logic                          s2_func;
  logic                          s2_ld_ok;
  isc_pkg::addr_t                s2_ld_addr;
  logic [isc_pkg::POS_W-1:0]     s2_py;
  logic [isc_pkg::POS_W-1:0]     s2_px;
  logic [isc_pkg::PIX_W-1:0]     s2_pix;

  logic [isc_pkg::ROW_W-1:0]     h_last;
  logic [isc_pkg::COL_W-1:0]     w_last;
  logic [isc_pkg::POS_W:0]       ny_pos;
  logic [isc_pkg::POS_W:0]       nx_pos;
  logic [isc_pkg::KN_W-1:0]      ny_k;
  logic [isc_pkg::KN_W-1:0]      nx_k;
  logic [isc_pkg::ROW_W-1:0]     ny;
  logic [isc_pkg::COL_W-1:0]     nx;
  logic [isc_pkg::KN_W-2:0]      by_k;
  logic [isc_pkg::KN_W-2:0]      bx_k;
  logic [isc_pkg::ROW_W-1:0]     y0;
  logic [isc_pkg::ROW_W-1:0]     y1;
  logic [isc_pkg::COL_W-1:0]     x0;
  logic [isc_pkg::COL_W-1:0]     x1;
  logic [isc_pkg::FRAC_BITS-1:0] fy;
  logic [isc_pkg::FRAC_BITS-1:0] fx;

  assign s2_free = !s2_valid || req_ready;
  assign s1_free = !s1_valid || s2_free;
  assign busy    = !s1_free;
  assign accept  = start && !busy;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_free) begin
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_func <= func;
      s1_row  <= row;
      s1_col  <= col;
      s1_pix  <= pix;
    end
  end

  // scale by the steps
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_free) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_free && s1_valid) begin
      s2_func    <= s1_func;
      s2_ld_ok   <= (s1_row < isc_pkg::COORD_W'(isc_pkg::MAX_SRC_HEIGHT)) &&
                    (s1_col < isc_pkg::COORD_W'(isc_pkg::MAX_SRC_WIDTH));
      s2_ld_addr <= {s1_row[isc_pkg::ROW_W-1:0], s1_col[isc_pkg::COL_W-1:0]};
      s2_py      <= isc_pkg::POS_W'(s1_row) * isc_pkg::POS_W'(row_step);
      s2_px      <= isc_pkg::POS_W'(s1_col) * isc_pkg::POS_W'(col_step);
      s2_pix     <= s1_pix;
    end
  end

  // last valid row and column: zero acts as one, oversize saturates
  always_comb begin
    if (src_height == '0) begin
      h_last = '0;
    end else if (src_height > isc_pkg::DIM_W'(isc_pkg::MAX_SRC_HEIGHT)) begin
      h_last = isc_pkg::ROW_W'(isc_pkg::MAX_SRC_HEIGHT - 1);
    end else begin
      h_last = isc_pkg::ROW_W'(src_height - 1'b1);
    end
    if (src_width == '0) begin
      w_last = '0;
    end else if (src_width > isc_pkg::DIM_W'(isc_pkg::MAX_SRC_WIDTH)) begin
      w_last = isc_pkg::COL_W'(isc_pkg::MAX_SRC_WIDTH - 1);
    end else begin
      w_last = isc_pkg::COL_W'(src_width - 1'b1);
    end
  end

  // nearest: round half up, clamp
  always_comb begin
    ny_pos = {1'b0, s2_py} + isc_pkg::HALF_FX;
    nx_pos = {1'b0, s2_px} + isc_pkg::HALF_FX;
    ny_k   = ny_pos[isc_pkg::POS_W:isc_pkg::FRAC_BITS];
    nx_k   = nx_pos[isc_pkg::POS_W:isc_pkg::FRAC_BITS];
    ny     = (ny_k > isc_pkg::KN_W'(h_last)) ? h_last : ny_k[isc_pkg::ROW_W-1:0];
    nx     = (nx_k > isc_pkg::KN_W'(w_last)) ? w_last : nx_k[isc_pkg::COL_W-1:0];
  end

  // bilinear: floor, neighbour one on, zero fraction at the far edge
  always_comb begin
    by_k = s2_py[isc_pkg::POS_W-1:isc_pkg::FRAC_BITS];
    bx_k = s2_px[isc_pkg::POS_W-1:isc_pkg::FRAC_BITS];
    if (by_k < (isc_pkg::KN_W - 1)'(h_last)) begin
      y0 = by_k[isc_pkg::ROW_W-1:0];
      y1 = by_k[isc_pkg::ROW_W-1:0] + 1'b1;
      fy = s2_py[isc_pkg::FRAC_BITS-1:0];
    end else begin
      y0 = h_last;
      y1 = h_last;
      fy = '0;
    end
    if (bx_k < (isc_pkg::KN_W - 1)'(w_last)) begin
      x0 = bx_k[isc_pkg::COL_W-1:0];
      x1 = bx_k[isc_pkg::COL_W-1:0] + 1'b1;
      fx = s2_px[isc_pkg::FRAC_BITS-1:0];
    end else begin
      x0 = w_last;
      x1 = w_last;
      fx = '0;
    end
  end

  always_comb begin
    req.is_load = (s2_func == isc_pkg::FUNC_LOAD);
    req.wr_en   = s2_ld_ok;
    req.bilin   = blend_mode;
    req.pix     = s2_pix;
    req.addr[1] = {y0, x1};
    req.addr[2] = {y1, x0};
    req.addr[3] = {y1, x1};
    if (s2_func == isc_pkg::FUNC_LOAD) begin
      req.addr[0] = s2_ld_addr;
      req.fx      = '0;
      req.fy      = '0;
    end else if (blend_mode) begin
      req.addr[0] = {y0, x0};
      req.fx      = fx;
      req.fy      = fy;
    end else begin
      req.addr[0] = {ny, nx};
      req.fx      = '0;
      req.fy      = '0;
    end
  end

  assign req_valid = s2_valid;

endmodule

`default_nettype wire

/* sv/isc_fetch.sv */
// ---------------------------------------------------------------------------
// isc_fetch - frame store access and neighbour gather
// Single-port frame memory: a load writes once, a nearest request reads
// once, a bilinear request reads its four neighbours in turn.
// ---------------------------------------------------------------------------
`default_nettype none

module isc_fetch (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  input  isc_pkg::fetch_req_t  req,
  output logic                 req_ready,
  output isc_pkg::quad_t       quad
);

  logic                          s3_valid;
  isc_pkg::fetch_req_t           s3_req;
  logic [1:0]                    s3_cnt;
  logic                          s3_last;

  logic [isc_pkg::PIX_W-1:0]     mem [isc_pkg::STORE_DEPTH];
  logic [isc_pkg::PIX_W-1:0]     mem_q;

  logic                          rd_valid;
  logic [1:0]                    rd_slot;
  logic                          rd_last;
  logic                          rd_bcast;
  logic [isc_pkg::FRAC_BITS-1:0] rd_fx;
  logic [isc_pkg::FRAC_BITS-1:0] rd_fy;

  logic                          q_valid;
  logic [isc_pkg::FRAC_BITS-1:0] q_fx;
  logic [isc_pkg::FRAC_BITS-1:0] q_fy;
  logic [3:0][isc_pkg::PIX_W-1:0] q_pix;

  assign s3_last   = s3_req.is_load || !s3_req.bilin || (s3_cnt == 2'd3);
  assign req_ready = !s3_valid || s3_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
      s3_cnt   <= '0;
    end else if (req_ready) begin
      s3_valid <= req_valid;
      s3_cnt   <= '0;
    end else begin
      s3_cnt   <= s3_cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (req_ready && req_valid) begin
      s3_req <= req;
    end
  end

  // frame store
  always_ff @(posedge clk) begin
    if (s3_valid && s3_req.is_load && s3_req.wr_en) begin
      mem[s3_req.addr[0]] <= s3_req.pix;
    end
    mem_q <= mem[s3_req.addr[s3_cnt]];
  end

  // read tag travels with the memory output
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid <= 1'b0;
    end else begin
      rd_valid <= s3_valid && !s3_req.is_load;
    end
  end

  always_ff @(posedge clk) begin
    rd_slot  <= s3_cnt;
    rd_last  <= s3_last;
    rd_bcast <= !s3_req.bilin;
    rd_fx    <= s3_req.fx;
    rd_fy    <= s3_req.fy;
  end

  // gather; a nearest read fills all four slots
  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
    end else begin
      q_valid <= rd_valid && rd_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_valid) begin
      if (rd_bcast) begin
        q_pix <= {4{mem_q}};
      end else begin
        q_pix[rd_slot] <= mem_q;
      end
      q_fx <= rd_fx;
      q_fy <= rd_fy;
    end
  end

  always_comb begin
    quad.valid = q_valid;
    quad.fx    = q_fx;
    quad.fy    = q_fy;
    quad.pix   = q_pix;
  end

endmodule

`default_nettype wire

/* sv/isc_lane.sv */
// ---------------------------------------------------------------------------
// isc_lane - bilinear blend of one colour channel
// Three register stages: horizontal products, horizontal sums, vertical
// products. The final add and truncation sit in the merge stage.
// ---------------------------------------------------------------------------
`default_nettype none

module isc_lane (
  input  logic                          clk,
  input  logic [isc_pkg::CH_W-1:0]      a,
  input  logic [isc_pkg::CH_W-1:0]      b,
  input  logic [isc_pkg::CH_W-1:0]      c,
  input  logic [isc_pkg::CH_W-1:0]      d,
  input  logic [isc_pkg::FRAC_BITS-1:0] fx,
  input  logic [isc_pkg::FRAC_BITS-1:0] fy,
  output isc_pkg::lane_prod_t           prod
);

  logic [isc_pkg::WT_W-1:0]      wx0;
  logic [isc_pkg::WT_W-1:0]      wy0;

  logic [isc_pkg::H_W-1:0]       ta;
  logic [isc_pkg::H_W-1:0]       tb;
  logic [isc_pkg::H_W-1:0]       tc;
  logic [isc_pkg::H_W-1:0]       td;
  logic [isc_pkg::FRAC_BITS-1:0] fy1;

  logic [isc_pkg::H_W-1:0]       top;
  logic [isc_pkg::H_W-1:0]       bot;
  logic [isc_pkg::FRAC_BITS-1:0] fy2;

  assign wx0 = isc_pkg::ONE_FX - isc_pkg::WT_W'(fx);
  assign wy0 = isc_pkg::ONE_FX - isc_pkg::WT_W'(fy2);

  // products stay below 2^H_W: byte times at most one
  always_ff @(posedge clk) begin
    ta  <= isc_pkg::H_W'(a) * isc_pkg::H_W'(wx0);
    tb  <= isc_pkg::H_W'(b) * isc_pkg::H_W'(fx);
    tc  <= isc_pkg::H_W'(c) * isc_pkg::H_W'(wx0);
    td  <= isc_pkg::H_W'(d) * isc_pkg::H_W'(fx);
    fy1 <= fy;
  end

  always_ff @(posedge clk) begin
    top <= ta + tb;
    bot <= tc + td;
    fy2 <= fy1;
  end

  always_ff @(posedge clk) begin
    prod.top <= isc_pkg::ACC_W'(top) * isc_pkg::ACC_W'(wy0);
    prod.bot <= isc_pkg::ACC_W'(bot) * isc_pkg::ACC_W'(fy2);
  end

endmodule

`default_nettype wire

/* sv/image_scaler_nearest_bilinear.sv */
// ---------------------------------------------------------------------------
// image_scaler_nearest_bilinear - nearest and bilinear image scaler
// Source frame store with three-channel pixels; requests map a destination
// coordinate into the source and return the scaled pixel.
// ---------------------------------------------------------------------------
// Usage:
//   Input beat: taken on a clock edge with start high and busy low. func
//   selects a load (row, col, in_ch0..2 written to the store) or a request
//   (row, col are destination coordinates).
//   Result beat: out_ch0..2 valid for the single cycle that done is high,
//   one per request, none per load. There is no back-pressure on results.
//   Configuration: cfg_we writes cfg_data to register cfg_idx at once;
//   write only while no request is in flight.
//   Path: a request passes the input, scale and fetch registers, the store
//   read, gather, blend lanes and merge before done rises; a bilinear
//   request adds the three extra store reads. Throughput: loads and nearest
//   requests one per cycle while no bilinear request holds the single frame
//   store port, which serves its four neighbour reads in turn. The next beat
//   is taken while earlier ones are still in the blend lanes.
//   Reset: empties the pipeline and restores the register defaults
//   (256 x 256 source, unit steps, nearest mode). The frame store keeps
//   its contents and needs no clearing; reading an unloaded pixel returns
//   an undefined value.
// ---------------------------------------------------------------------------
`default_nettype none

module image_scaler_nearest_bilinear (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic                            func,
  input  logic [isc_pkg::COORD_W-1:0]     row,
  input  logic [isc_pkg::COORD_W-1:0]     col,
  input  logic [isc_pkg::CH_W-1:0]        in_ch0,
  input  logic [isc_pkg::CH_W-1:0]        in_ch1,
  input  logic [isc_pkg::CH_W-1:0]        in_ch2,
  output logic                            done,
  output logic [isc_pkg::CH_W-1:0]        out_ch0,
  output logic [isc_pkg::CH_W-1:0]        out_ch1,
  output logic [isc_pkg::CH_W-1:0]        out_ch2,
  input  logic                            cfg_we,
  input  logic [isc_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  logic [isc_pkg::STEP_W-1:0]      cfg_data
);

  logic [isc_pkg::DIM_W-1:0]   src_width;
  logic [isc_pkg::DIM_W-1:0]   src_height;
  logic [isc_pkg::STEP_W-1:0]  row_step;
  logic [isc_pkg::STEP_W-1:0]  col_step;
  logic                        blend_mode;

  logic                        req_valid;
  logic                        req_ready;
  isc_pkg::fetch_req_t         req;
  isc_pkg::quad_t              quad;

  isc_pkg::lane_prod_t         lp [isc_pkg::NUM_CH];
  logic [isc_pkg::CH_W-1:0]    out_byte [isc_pkg::NUM_CH];
  logic [2:0]                  lane_vld;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      src_width   <= isc_pkg::SRC_WIDTH_RST;
      src_height  <= isc_pkg::SRC_HEIGHT_RST;
      row_step    <= isc_pkg::STEP_RST;
      col_step    <= isc_pkg::STEP_RST;
      blend_mode  <= 1'b0;
    end else if (cfg_we) begin
      case (isc_pkg::cfg_reg_t'(cfg_idx))
        isc_pkg::REG_SRC_WIDTH:  src_width   <= cfg_data[isc_pkg::DIM_W-1:0];
        isc_pkg::REG_SRC_HEIGHT: src_height  <= cfg_data[isc_pkg::DIM_W-1:0];
        isc_pkg::REG_ROW_STEP:   row_step    <= cfg_data;
        isc_pkg::REG_COL_STEP:   col_step    <= cfg_data;
        isc_pkg::REG_INTERP:     blend_mode  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  isc_coord u_coord (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .func        (func),
    .row         (row),
    .col         (col),
    .pix         ({in_ch2, in_ch1, in_ch0}),
    .src_width   (src_width),
    .src_height  (src_height),
    .row_step    (row_step),
    .col_step    (col_step),
    .blend_mode  (blend_mode),
    .req_ready   (req_ready),
    .busy        (busy),
    .req_valid   (req_valid),
    .req         (req)
  );

  isc_fetch u_fetch (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req       (req),
    .req_ready (req_ready),
    .quad      (quad)
  );

  for (genvar ch = 0; ch < isc_pkg::NUM_CH; ch++) begin : g_lane
    isc_lane u_lane (
      .clk  (clk),
      .a    (quad.pix[0][ch*isc_pkg::CH_W +: isc_pkg::CH_W]),
      .b    (quad.pix[1][ch*isc_pkg::CH_W +: isc_pkg::CH_W]),
      .c    (quad.pix[2][ch*isc_pkg::CH_W +: isc_pkg::CH_W]),
      .d    (quad.pix[3][ch*isc_pkg::CH_W +: isc_pkg::CH_W]),
      .fx   (quad.fx),
      .fy   (quad.fy),
      .prod (lp[ch])
    );

    // merge: add the vertical terms and truncate the fraction
    always_ff @(posedge clk) begin
      out_byte[ch] <= isc_pkg::CH_W'((lp[ch].top + lp[ch].bot)
                      >> (2 * isc_pkg::FRAC_BITS));
    end
  end

  // valid alongside the lane stages
  always_ff @(posedge clk) begin
    if (rst) begin
      lane_vld <= '0;
      done     <= 1'b0;
    end else begin
      lane_vld <= {lane_vld[1:0], quad.valid};
      done     <= lane_vld[2];
    end
  end

  assign out_ch0 = out_byte[0];
  assign out_ch1 = out_byte[1];
  assign out_ch2 = out_byte[2];

endmodule

`default_nettype wire

/* sv/isc_checker.sv */
// ---------------------------------------------------------------------------
// isc_checker - port-level checks of the image scaler
// Watches the command and result ports over time; bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

module isc_checker (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic done
);

  // reset empties the pipeline
  a_reset_idle: assert property (@(posedge clk)
    rst |=> (!busy && !done))
    else $error("busy or done after reset");

  // checks that busy rises only after a beat taken on the edge before
  a_busy_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> $past(start && !busy))
    else $error("busy rose with no beat taken");

  // a result needs the whole pipeline after reset
  a_min_latency: assert property (@(posedge clk) disable iff (rst)
    done |-> !($past(rst, 1) || $past(rst, 2) || $past(rst, 3) ||
               $past(rst, 4) || $past(rst, 5) || $past(rst, 6) ||
               $past(rst, 7) || $past(rst, 8)))
    else $error("result strobe too soon after reset");

endmodule

bind image_scaler_nearest_bilinear isc_checker u_isc_checker (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .done  (done)
);

`default_nettype wire

/* tb/image_scaler_checker.sv */
// ---------------------------------------------------------------------------
// image_scaler_checker - scoreboard for the nearest and bilinear scaler
// Mirrors the register writes and pixel loads seen on the ports, predicts
// the pixel of every accepted request and compares it channel by channel
// with the next done beat. The coordinate mapping lives in scaler_tb_pkg
// so that the stimulus can pre-load every pixel a request will read.
// ---------------------------------------------------------------------------
`default_nettype none

package scaler_tb_pkg;
  import isc_pkg::*;

  // index outside the register map; writes to it must change nothing
  localparam logic [CFG_IDX_W-1:0] SPARE_REG_IDX = 3'd7;

  typedef struct packed {
    logic [DIM_W-1:0]  width;
    logic [DIM_W-1:0]  height;
    logic [STEP_W-1:0] row_step;
    logic [STEP_W-1:0] col_step;
    logic              bilinear;
  } scaler_cfg_t;

  localparam scaler_cfg_t RESET_CFG =
    '{SRC_WIDTH_RST, SRC_HEIGHT_RST, STEP_RST, STEP_RST, 1'b0};

  // store addresses read by one request: top-left, top-right,
  // bottom-left, bottom-right, with the blend fractions
  typedef struct packed {
    addr_t [3:0]          tap;
    logic [FRAC_BITS-1:0] fx;
    logic [FRAC_BITS-1:0] fy;
  } src_taps_t;

  // zero acts as one, anything past the store saturates
  function automatic int unsigned eff_dim(logic [DIM_W-1:0] v, int unsigned limit);
    if (v == '0) return 1;
    if (v > limit) return limit;
    return v;
  endfunction

  function automatic void map_axis(input longint unsigned pos, input int unsigned dim,
                                   input logic bilinear, output int unsigned i0,
                                   output int unsigned i1,
                                   output logic [FRAC_BITS-1:0] frac);
    longint unsigned k;
    if (!bilinear) begin
      // round half up, clamp to the last line
      k = (pos + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
      if (k > dim - 1) k = dim - 1;
      i0 = k;
      i1 = k;
      frac = '0;
    end else begin
      k = pos >> FRAC_BITS;
      if (k < dim - 1) begin
        i0 = k;
        i1 = k + 1;
        frac = pos[FRAC_BITS-1:0];
      end else begin
        // at or past the last line the neighbour is the pixel itself
        i0 = dim - 1;
        i1 = dim - 1;
        frac = '0;
      end
    end
  endfunction

  function automatic src_taps_t map_request(scaler_cfg_t c, logic [COORD_W-1:0] r,
                                            logic [COORD_W-1:0] k);
    int unsigned y0, y1, x0, x1;
    src_taps_t   t;
    map_axis(64'(r) * 64'(c.row_step), eff_dim(c.height, MAX_SRC_HEIGHT), c.bilinear,
             y0, y1, t.fy);
    map_axis(64'(k) * 64'(c.col_step), eff_dim(c.width, MAX_SRC_WIDTH), c.bilinear,
             x0, x1, t.fx);
    t.tap[0] = addr_t'(y0 * MAX_SRC_WIDTH + x0);
    t.tap[1] = addr_t'(y0 * MAX_SRC_WIDTH + x1);
    t.tap[2] = addr_t'(y1 * MAX_SRC_WIDTH + x0);
    t.tap[3] = addr_t'(y1 * MAX_SRC_WIDTH + x1);
    return t;
  endfunction

endpackage

module image_scaler_checker
  import isc_pkg::*;
  import scaler_tb_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               busy,
  input  logic               func,
  input  logic [COORD_W-1:0] row,
  input  logic [COORD_W-1:0] col,
  input  logic [CH_W-1:0]    in_ch0,
  input  logic [CH_W-1:0]    in_ch1,
  input  logic [CH_W-1:0]    in_ch2,
  input  logic               done,
  input  logic [CH_W-1:0]    out_ch0,
  input  logic [CH_W-1:0]    out_ch1,
  input  logic [CH_W-1:0]    out_ch2,
  input  logic               cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [STEP_W-1:0]  cfg_data,
  output int                 fail_count,
  output int                 pending
);

  logic [PIX_W-1:0] shadow_store [STORE_DEPTH];
  logic [PIX_W-1:0] expected_pixels [$];
  scaler_cfg_t      regs;
  int               errors;

  function automatic logic [PIX_W-1:0] scale_pixel(logic [COORD_W-1:0] r,
                                                   logic [COORD_W-1:0] c);
    src_taps_t        t;
    logic [PIX_W-1:0] quad [4];
    longint unsigned  one, a, b, p, q, top_term, bot_term, acc;
    logic [PIX_W-1:0] result;
    one = 64'd1 << FRAC_BITS;
    t = map_request(regs, r, c);
    for (int i = 0; i < 4; i++) quad[i] = shadow_store[t.tap[i]];
    // nearest taps are all equal with zero fractions, so one blend serves both
    for (int ch = 0; ch < NUM_CH; ch++) begin
      a = quad[0][ch*CH_W +: CH_W];
      b = quad[1][ch*CH_W +: CH_W];
      p = quad[2][ch*CH_W +: CH_W];
      q = quad[3][ch*CH_W +: CH_W];
      top_term = a * (one - t.fx) + b * t.fx;
      bot_term = p * (one - t.fx) + q * t.fx;
      acc = top_term * (one - t.fy) + bot_term * t.fy;
      result[ch*CH_W +: CH_W] = acc[2*FRAC_BITS +: CH_W];
    end
    return result;
  endfunction

  always @(posedge clk) begin
    logic [PIX_W-1:0] got, want;
    if (rst) begin
      regs = RESET_CFG;
      expected_pixels.delete();
      errors = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          REG_SRC_WIDTH:  regs.width    = cfg_data[DIM_W-1:0];
          REG_SRC_HEIGHT: regs.height   = cfg_data[DIM_W-1:0];
          REG_ROW_STEP:   regs.row_step = cfg_data;
          REG_COL_STEP:   regs.col_step = cfg_data;
          REG_INTERP:     regs.bilinear = cfg_data[0];
          default: ;
        endcase
      end
      // retire before taking the new beat: a result never leaves on its own edge
      if (done) begin
        got = {out_ch2, out_ch1, out_ch0};
        if (expected_pixels.size() == 0) begin
          $display("%0t: result %06h with no request outstanding", $time, got);
          errors++;
        end else begin
          want = expected_pixels.pop_front();
          for (int ch = 0; ch < NUM_CH; ch++) begin
            if (got[ch*CH_W +: CH_W] !== want[ch*CH_W +: CH_W]) begin
              $display("%0t: out_ch%0d expected %02h got %02h", $time, ch,
                       want[ch*CH_W +: CH_W], got[ch*CH_W +: CH_W]);
              errors++;
            end
          end
        end
      end
      if (start && !busy) begin
        if (func == FUNC_REQUEST)
          expected_pixels.push_back(scale_pixel(row, col));
        else if (row < MAX_SRC_HEIGHT && col < MAX_SRC_WIDTH)
          shadow_store[{row[ROW_W-1:0], col[COL_W-1:0]}] = {in_ch2, in_ch1, in_ch0};
      end
    end
    fail_count <= errors;
    pending    <= expected_pixels.size();
  end

endmodule

`default_nettype wire

/* tb/image_scaler_nearest_bilinear_test.sv */
// ---------------------------------------------------------------------------
// image_scaler_nearest_bilinear_test - top of the scaler testbench
// Drives loads and requests with random gaps through a directed set of
// corner cases and then random phases, each with its own register setting.
// Every pixel a request will read is loaded first. The checker does the
// prediction; this module gives the verdict.
// ---------------------------------------------------------------------------
`default_nettype none

module image_scaler_nearest_bilinear_test;
  import isc_pkg::*;
  import scaler_tb_pkg::*;

  localparam int              RANDOM_ITEMS   = 1800;
  localparam int              SETTLE_CYCLES  = 16;
  localparam int              WATCHDOG_LIMIT = 1000;
  localparam int unsigned     ONE_STEP       = 1 << FRAC_BITS;
  localparam logic [STEP_W-1:0] STEP_MAX     = STEP_W'(1 << 24);

  logic               clk = 1'b0;
  logic               rst;
  logic               start;
  logic               busy;
  logic               func;
  logic [COORD_W-1:0] row;
  logic [COORD_W-1:0] col;
  logic [CH_W-1:0]    in_ch0;
  logic [CH_W-1:0]    in_ch1;
  logic [CH_W-1:0]    in_ch2;
  logic               done;
  logic [CH_W-1:0]    out_ch0;
  logic [CH_W-1:0]    out_ch1;
  logic [CH_W-1:0]    out_ch2;
  logic               cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [STEP_W-1:0]  cfg_data;
  int                 fail_count;
  int                 pending;

  scaler_cfg_t        cur_cfg;
  bit                 loaded [STORE_DEPTH];
  int                 items_sent;
  bit                 no_gaps;
  int                 idle_cycles;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  image_scaler_nearest_bilinear u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .func(func),
    .row(row), .col(col), .in_ch0(in_ch0), .in_ch1(in_ch1), .in_ch2(in_ch2),
    .done(done), .out_ch0(out_ch0), .out_ch1(out_ch1), .out_ch2(out_ch2),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
  );

  image_scaler_checker u_checker (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .func(func),
    .row(row), .col(col), .in_ch0(in_ch0), .in_ch1(in_ch1), .in_ch2(in_ch2),
    .done(done), .out_ch0(out_ch0), .out_ch1(out_ch1), .out_ch2(out_ch2),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending(pending)
  );

  // mostly back to back or short, now and then a long pause
  function automatic int unsigned pick_gap();
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (no_gaps || sel < 55) return 0;
    if (sel < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  function automatic logic [DIM_W-1:0] pick_dim();
    int unsigned sel;
    sel = $urandom_range(0, 19);
    if (sel < 13) return $urandom_range(1, 16);
    if (sel < 15) return $urandom_range(17, 255);
    if (sel < 17) return DIM_W'(MAX_SRC_WIDTH);
    if (sel < 18) return '0;
    return $urandom_range(257, 511);
  endfunction

  function automatic logic [STEP_W-1:0] pick_step();
    int unsigned sel;
    sel = $urandom_range(0, 9);
    if (sel < 5) return $urandom_range(0, 3 * ONE_STEP);
    if (sel < 6) return '0;
    if (sel < 7) return STEP_MAX;
    return $urandom_range(0, STEP_MAX);
  endfunction

  // keep most coordinates where the scaled position lands inside the image
  function automatic int unsigned pick_coord(int unsigned dim, logic [STEP_W-1:0] step);
    longint unsigned span;
    if ($urandom_range(0, 3) == 0 || step == '0) return $urandom_range(0, 4095);
    span = (64'(dim) + 1) * ONE_STEP / step;
    if (span > 4095) span = 4095;
    return $urandom_range(0, span);
  endfunction

  task automatic put_beat(func_t f, logic [COORD_W-1:0] r, logic [COORD_W-1:0] c,
                          logic [PIX_W-1:0] pix);
    int unsigned gap;
    start <= 1'b1;
    func  <= f;
    row   <= r;
    col   <= c;
    {in_ch2, in_ch1, in_ch0} <= pix;
    @(posedge clk);
    while (busy) @(posedge clk);
    items_sent++;
    if (f == FUNC_LOAD && r < MAX_SRC_HEIGHT && c < MAX_SRC_WIDTH)
      loaded[{r[ROW_W-1:0], c[COL_W-1:0]}] = 1'b1;
    gap = pick_gap();
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // load any tap not yet written, then ask for the pixel
  task automatic request_pixel(logic [COORD_W-1:0] r, logic [COORD_W-1:0] c);
    src_taps_t t;
    t = map_request(cur_cfg, r, c);
    for (int i = 0; i < 4; i++) begin
      if (!loaded[t.tap[i]])
        put_beat(FUNC_LOAD, t.tap[i][ADDR_W-1:COL_W], t.tap[i][COL_W-1:0], $urandom);
    end
    put_beat(FUNC_REQUEST, r, c, $urandom);
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    // loads leave no result to wait for; let the pipeline empty
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_reg(logic [CFG_IDX_W-1:0] idx, logic [STEP_W-1:0] data);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk);
    case (idx)
      REG_SRC_WIDTH:  cur_cfg.width    = data[DIM_W-1:0];
      REG_SRC_HEIGHT: cur_cfg.height   = data[DIM_W-1:0];
      REG_ROW_STEP:   cur_cfg.row_step = data;
      REG_COL_STEP:   cur_cfg.col_step = data;
      REG_INTERP:     cur_cfg.bilinear = data[0];
      default: ;
    endcase
  endtask

  // upper bits of the narrow registers carry junk that must be dropped
  task automatic configure(scaler_cfg_t c);
    drain();
    set_reg(REG_SRC_WIDTH, {16'($urandom), c.width});
    set_reg(REG_SRC_HEIGHT, {16'($urandom), c.height});
    set_reg(REG_ROW_STEP, c.row_step);
    set_reg(REG_COL_STEP, c.col_step);
    set_reg(REG_INTERP, {24'($urandom), c.bilinear});
    if ($urandom_range(0, 4) == 0) set_reg(SPARE_REG_IDX, STEP_W'($urandom));
    cfg_we <= 1'b0;
  endtask

  task automatic random_item();
    int unsigned w, h, sel;
    w = eff_dim(cur_cfg.width, MAX_SRC_WIDTH);
    h = eff_dim(cur_cfg.height, MAX_SRC_HEIGHT);
    sel = $urandom_range(0, 99);
    if (sel < 18)
      put_beat(FUNC_LOAD, $urandom_range(0, h - 1), $urandom_range(0, w - 1), $urandom);
    else if (sel < 22)
      put_beat(FUNC_LOAD, $urandom_range(0, 255), $urandom_range(0, 255), $urandom);
    else if (sel < 25)
      put_beat(FUNC_LOAD, $urandom_range(0, 4095), $urandom_range(0, 4095), $urandom);
    else
      request_pixel(pick_coord(h, cur_cfg.row_step), pick_coord(w, cur_cfg.col_step));
  endtask

  always @(posedge clk) begin
    if (rst || (start && !busy) || done || cfg_we) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst      = 1'b1;
    start    = 1'b0;
    func     = FUNC_LOAD;
    row      = '0;
    col      = '0;
    in_ch0   = '0;
    in_ch1   = '0;
    in_ch2   = '0;
    cfg_we   = 1'b0;
    cfg_idx  = REG_SRC_WIDTH;
    cfg_data = '0;
    cur_cfg  = RESET_CFG;
    items_sent = 0;
    no_gaps  = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // store corners at reset defaults; loads beyond the store are dropped
    put_beat(FUNC_LOAD, 0, 0, 24'h000000);
    put_beat(FUNC_LOAD, 255, 255, 24'hFFFFFF);
    put_beat(FUNC_LOAD, 0, 255, 24'h5AA55A);
    put_beat(FUNC_LOAD, 255, 0, 24'hA55AA5);
    put_beat(FUNC_LOAD, 256, 0, $urandom);
    put_beat(FUNC_LOAD, 0, 256, $urandom);
    put_beat(FUNC_LOAD, 4095, 4095, $urandom);
    request_pixel(0, 0);
    request_pixel(4095, 4095);
    request_pixel(0, 4095);
    request_pixel(255, 0);

    // bilinear at half steps on a 2 x 2 image, with clamping past the edge
    configure('{9'd2, 9'd2, 25'(ONE_STEP / 2), 25'(ONE_STEP / 2), 1'b1});
    request_pixel(0, 0);
    request_pixel(1, 1);
    request_pixel(1, 2);
    request_pixel(3, 3);
    request_pixel(4095, 4095);

    // zero width, oversize height, zero and largest steps
    configure('{9'd0, 9'd511, 25'd0, STEP_MAX, 1'b0});
    request_pixel(5, 1);
    request_pixel(4095, 0);
    configure('{9'd1, 9'd256, STEP_MAX, 25'd0, 1'b1});
    request_pixel(1, 4095);
    request_pixel(0, 7);

    items_sent = 0;
    while (items_sent < RANDOM_ITEMS) begin
      configure('{pick_dim(), pick_dim(), pick_step(), pick_step(), 1'($urandom)});
      no_gaps = ($urandom_range(0, 3) == 0);
      repeat ($urandom_range(60, 200)) begin
        if (items_sent < RANDOM_ITEMS) random_item();
      end
    end

    drain();
    if (fail_count == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule

`default_nettype wire
